[sv/gtrav_pkg.sv]
// Package for the graph traversal block: state encoding, request codes,
// configuration register indexes and fixed field widths. No dependencies.
package gtrav_pkg;

    localparam int FIELD_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_DATA_W-1:0] ACTIVE_RESET = 5'd16;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RUN   = 1'b1;

    localparam logic MODE_BFS = 1'b0;
    localparam logic MODE_DFS = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_NODES   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVERSAL_MODE = 1'd1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WR_RD,
        S_WR_WR,
        S_BFS_POP,
        S_BFS_CUR,
        S_DFS_POP,
        S_DFS_CHK,
        S_VISIT,
        S_LOAD,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

[sv/gtrav_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gtrav_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/graph_traversal_bfs_dfs.sv]
// Graph traversal (breadth-first / depth-first) over an adjacency matrix RAM.
// Depends on gtrav_pkg and gtrav_ram.
// Edge write request: the row is read, then written back with one bit changed. Run
// request: per visited node its row is loaded and scanned, one adjacency bit checked
// per cycle by the scan sequencer; stale DFS pops are dropped; one request at a time.
// Reset: synchronous; a clearing pass then zeroes the adjacency RAM one row per cycle,
// requests are stalled meanwhile (configuration still taken).
module graph_traversal_bfs_dfs
    import gtrav_pkg::*;
#(
    parameter int NODES       = 16,
    parameter int STACK_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [FIELD_W-1:0]    i_row,
    input  logic [FIELD_W-1:0]    i_col,
    input  logic                  i_edge_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [FIELD_W-1:0]    o_node,
    output logic                  o_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW  = $clog2(NODES);
    localparam int SW  = $clog2(NODES + 1);
    localparam int STW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW  = $clog2(STACK_DEPTH + 1);

    t_state                r_state, n_state;
    logic [AW-1:0]         r_clr, n_clr;
    logic [CFG_DATA_W-1:0] r_active;
    logic                  r_mode;
    logic [AW-1:0]         r_wrow, n_wrow;
    logic [AW-1:0]         r_wcol, n_wcol;
    logic                  r_wedge, n_wedge;
    logic [SW-1:0]         r_size, n_size;
    logic [NODES-1:0]      r_visited, n_visited;
    logic [AW-1:0]         r_qhead, n_qhead;
    logic [AW-1:0]         r_qtail, n_qtail;
    logic [SW-1:0]         r_qfill, n_qfill;
    logic [CW-1:0]         r_scount, n_scount;
    logic [AW-1:0]         r_cur, n_cur;
    logic [NODES-1:0]      r_rowbits, n_rowbits;
    logic [AW-1:0]         r_i, n_i;
    logic [AW-1:0]         r_held, n_held;
    logic                  r_held_v, n_held_v;
    logic                  r_out_valid, n_out_valid;
    logic [FIELD_W-1:0]    r_out_node, n_out_node;
    logic                  r_out_last, n_out_last;

    logic                  adj_we, adj_re;
    logic [AW-1:0]         adj_waddr, adj_raddr;
    logic [NODES-1:0]      adj_wdata, adj_rdata;
    logic                  q_we, q_re;
    logic [AW-1:0]         q_waddr, q_raddr, q_wdata, q_rdata;
    logic                  s_we, s_re;
    logic [STW-1:0]        s_waddr, s_raddr;
    logic [AW-1:0]         s_wdata, s_rdata;

    logic                  out_free;
    logic                  emit, emit_last;

    gtrav_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_re    (adj_re),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    gtrav_ram #(.WIDTH(AW), .DEPTH(NODES)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    gtrav_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_node      = r_out_node;
    assign o_last      = r_out_last;

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_wrow    = r_wrow;
        n_wcol    = r_wcol;
        n_wedge   = r_wedge;
        n_size    = r_size;
        n_visited = r_visited;
        n_qhead   = r_qhead;
        n_qtail   = r_qtail;
        n_qfill   = r_qfill;
        n_scount  = r_scount;
        n_cur     = r_cur;
        n_rowbits = r_rowbits;
        n_i       = r_i;
        n_held    = r_held;
        n_held_v  = r_held_v;
        emit      = 1'b0;
        emit_last = 1'b0;
        adj_we    = 1'b0;
        adj_waddr = r_wrow;
        adj_wdata = '0;
        adj_re    = 1'b0;
        adj_raddr = r_cur;
        q_we      = 1'b0;
        q_waddr   = r_qtail;
        q_wdata   = r_i;
        q_re      = 1'b0;
        q_raddr   = r_qhead;
        s_we      = 1'b0;
        s_waddr   = STW'(r_scount);
        s_wdata   = r_i;
        s_re      = 1'b0;
        s_raddr   = STW'(r_scount - CW'(1));

        case (r_state)
            S_CLEAR: begin
                adj_we    = 1'b1;
                adj_waddr = r_clr;
                adj_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_op)
                        OP_WRITE: begin
                            if (32'(i_row) < NODES && 32'(i_col) < NODES) begin
                                n_wrow  = AW'(i_row);
                                n_wcol  = AW'(i_col);
                                n_wedge = i_edge_req;
                                n_state = S_WR_RD;
                            end
                        end
                        OP_RUN: begin
                            if (r_active == '0) begin
                                n_size = SW'(1);
                            end else if (32'(r_active) > NODES) begin
                                n_size = SW'(NODES);
                            end else begin
                                n_size = SW'(r_active);
                            end
                            n_held_v = 1'b0;
                            if (r_mode == MODE_DFS) begin
                                n_visited = '0;
                                s_we      = 1'b1;
                                s_waddr   = '0;
                                s_wdata   = '0;
                                n_scount  = CW'(1);
                                n_state   = S_DFS_POP;
                            end else begin
                                n_visited = NODES'(1);
                                q_we      = 1'b1;
                                q_waddr   = '0;
                                q_wdata   = '0;
                                n_qhead   = '0;
                                n_qtail   = AW'(1);
                                n_qfill   = SW'(1);
                                n_state   = S_BFS_POP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WR_RD: begin
                adj_re    = 1'b1;
                adj_raddr = r_wrow;
                n_state   = S_WR_WR;
            end
            S_WR_WR: begin
                adj_we            = 1'b1;
                adj_waddr         = r_wrow;
                adj_wdata         = adj_rdata;
                adj_wdata[r_wcol] = r_wedge;
                n_state           = S_IDLE;
            end
            S_BFS_POP: begin
                if (r_qfill == '0) begin
                    n_state = S_FINISH;
                end else begin
                    q_re    = 1'b1;
                    n_qhead = (r_qhead == AW'(NODES - 1)) ? '0 : r_qhead + AW'(1);
                    n_qfill = r_qfill - SW'(1);
                    n_state = S_BFS_CUR;
                end
            end
            S_BFS_CUR: begin
                n_cur   = q_rdata;
                n_state = S_VISIT;
            end
            S_DFS_POP: begin
                if (r_scount == '0) begin
                    n_state = S_FINISH;
                end else begin
                    s_re     = 1'b1;
                    n_scount = r_scount - CW'(1);
                    n_state  = S_DFS_CHK;
                end
            end
            S_DFS_CHK: begin
                if (SW'(s_rdata) >= r_size) begin
                    n_state = S_DFS_POP;
                end else if (r_visited[s_rdata]) begin
                    n_state = S_DFS_POP;
                end else begin
                    n_visited[s_rdata] = 1'b1;
                    n_cur              = s_rdata;
                    n_state            = S_VISIT;
                end
            end
            S_VISIT: begin
                // previous node is now known not to be the final one
                emit = r_held_v;
                if (!r_held_v || out_free) begin
                    n_held    = r_cur;
                    n_held_v  = 1'b1;
                    adj_re    = 1'b1;
                    adj_raddr = r_cur;
                    n_state   = S_LOAD;
                end
            end
            S_LOAD: begin
                n_rowbits = adj_rdata;
                n_i       = '0;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                if (!r_visited[r_i] && r_rowbits[r_i]) begin
                    if (r_mode == MODE_DFS) begin
                        if (r_scount < CW'(STACK_DEPTH)) begin
                            s_we     = 1'b1;
                            n_scount = r_scount + CW'(1);
                        end
                    end else begin
                        n_visited[r_i] = 1'b1;
                        if (32'(r_qfill) < NODES) begin
                            q_we    = 1'b1;
                            n_qtail = (r_qtail == AW'(NODES - 1)) ? '0 : r_qtail + AW'(1);
                            n_qfill = r_qfill + SW'(1);
                        end
                    end
                end
                if (SW'(r_i) + SW'(1) == r_size) begin
                    n_state = (r_mode == MODE_DFS) ? S_DFS_POP : S_BFS_POP;
                end else begin
                    n_i = r_i + AW'(1);
                end
            end
            S_FINISH: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                if (out_free) begin
                    n_held_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        n_out_node  = r_out_node;
        n_out_last  = r_out_last;
        if (out_free) begin
            n_out_valid = emit;
            if (emit) begin
                n_out_node = FIELD_W'(r_held);
                n_out_last = emit_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_active    <= ACTIVE_RESET;
            r_mode      <= MODE_BFS;
            r_visited   <= '0;
            r_qhead     <= '0;
            r_qtail     <= '0;
            r_qfill     <= '0;
            r_scount    <= '0;
            r_held_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_visited   <= n_visited;
            r_qhead     <= n_qhead;
            r_qtail     <= n_qtail;
            r_qfill     <= n_qfill;
            r_scount    <= n_scount;
            r_held_v    <= n_held_v;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ACTIVE_NODES: begin
                        r_active <= i_cfg_data;
                    end
                    CFG_TRAVERSAL_MODE: begin
                        r_mode <= i_cfg_data[0];
                    end
                    default: begin
                        r_mode <= r_mode;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wrow     <= n_wrow;
        r_wcol     <= n_wcol;
        r_wedge    <= n_wedge;
        r_size     <= n_size;
        r_cur      <= n_cur;
        r_rowbits  <= n_rowbits;
        r_i        <= n_i;
        r_held     <= n_held;
        r_out_node <= n_out_node;
        r_out_last <= n_out_last;
    end

    a_qfill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_qfill) <= NODES)
        else $error("queue fill above node count");

    a_scount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_scount) <= STACK_DEPTH)
        else $error("stack count above depth");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (SW'(r_i) < r_size))
        else $error("scan index beyond active nodes");

    a_finish_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> r_held_v)
        else $error("run finished without a visited node");

    a_scan_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> r_visited[0])
        else $error("root node not marked visited during scan");

endmodule

[tb/sv/tb_graph_traversal_bfs_dfs.sv]
`timescale 1ns / 100ps
// Self-checking testbench for graph_traversal_bfs_dfs: edge write and run requests are
// driven from a queue, visit orders are predicted in breadth-first and depth-first mode.
// Depends on gtrav_pkg and the graph_traversal_bfs_dfs RTL.
module tb_graph_traversal_bfs_dfs
    import gtrav_pkg::*;
();

    localparam int NODES       = 16;
    localparam int STACK_DEPTH = 256;
    localparam int LIMIT       = 1_000_000;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic               op;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic               edge_req;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0] node;
        logic               last;
    } t_visit;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_op        = OP_WRITE;
    logic [FIELD_W-1:0]    i_row       = '0;
    logic [FIELD_W-1:0]    i_col       = '0;
    logic                  i_edge_req  = 1'b0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_ACTIVE_NODES;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [FIELD_W-1:0]    o_node;
    logic                  o_last;
    logic                  o_cfg_ready;

    t_req                  pending_reqs[$];
    t_visit                visits_due[$];
    logic [NODES-1:0]      adj_rows[NODES] = '{default: '0};
    logic [CFG_DATA_W-1:0] active_cfg = ACTIVE_RESET;
    logic                  mode_cfg   = MODE_BFS;
    int                    mismatches = 0;
    int                    hold_left  = 0;
    bit                    hold_req   = 1'b0;
    bit                    hold_done  = 1'b0;
    bit                    calm       = 1'b0;
    int                    cycle_cnt  = 0;

    graph_traversal_bfs_dfs #(
        .NODES       (NODES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_edge_req  (i_edge_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_node      (o_node),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Visit order of one run from node 0, queued as expected results.
    function automatic void predict_visits(input logic [CFG_DATA_W-1:0] act, input logic mode);
        int               size;
        int               cnt;
        int               head;
        int               fill;
        int               cur;
        int               i;
        logic [NODES-1:0] seen;
        int               ring[NODES];
        int               stk[STACK_DEPTH];
        int               order[$];
        t_visit           v;
        size = (act == 0) ? 1 : (act > NODES) ? NODES : int'(act);
        seen = '0;
        if (mode == MODE_BFS) begin
            head    = 0;
            fill    = 1;
            ring[0] = 0;
            seen[0] = 1'b1;
            while (fill != 0) begin
                cur  = ring[head];
                head = (head + 1) % NODES;
                fill--;
                order.push_back(cur);
                for (i = 0; i < size; i++) begin
                    if (!seen[i] && adj_rows[cur][i]) begin
                        seen[i] = 1'b1;
                        if (fill < NODES) begin
                            ring[(head + fill) % NODES] = i;
                            fill++;
                        end
                    end
                end
            end
        end else begin
            cnt    = 1;
            stk[0] = 0;
            while (cnt != 0) begin
                cnt--;
                cur = stk[cnt];
                if (cur < size && !seen[cur]) begin
                    seen[cur] = 1'b1;
                    order.push_back(cur);
                    for (i = 0; i < size; i++) begin
                        if (!seen[i] && adj_rows[cur][i] && cnt < STACK_DEPTH) begin
                            stk[cnt] = i;
                            cnt++;
                        end
                    end
                end
            end
        end
        foreach (order[k]) begin
            v.node = FIELD_W'(order[k]);
            v.last = (k == order.size() - 1);
            visits_due.push_back(v);
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (i_op == OP_RUN) begin
                    predict_visits(active_cfg, mode_cfg);
                end else begin
                    adj_rows[i_row][i_col] = i_edge_req;
                end
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
                    nxt = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_op       <= nxt.op;
                    i_row      <= nxt.row;
                    i_col      <= nxt.col;
                    i_edge_req <= nxt.edge_req;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_visit want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (visits_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: node %0d last %0b", o_node, o_last);
                end else begin
                    want = visits_due.pop_front();
                    if (o_node !== want.node || o_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: node exp %0d got %0d, last exp %0b got %0b",
                                     want.node, o_node, want.last, o_last);
                    end
                end
            end
            i_out_stall <= (hold_left != 0) || (!calm && $urandom_range(0, 99) < 28);
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ACTIVE_NODES)
            active_cfg = val;
        else
            mode_cfg = val[0];
    endtask

    task automatic add_req(input logic op, input int row, input int col, input logic e);
        t_req r;
        r.op       = op;
        r.row      = FIELD_W'(row);
        r.col      = FIELD_W'(col);
        r.edge_req = e;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || visits_due.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        int rand_items;
        int phase;
        int act;
        int lim;
        int nruns;
        int nw;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty graph, self loops, corner nodes, edge clear, size clamps
        @(negedge i_clk);
        add_req(OP_RUN, 0, 0, 1'b0);
        add_req(OP_WRITE, 0, 15, 1'b1);
        add_req(OP_WRITE, 15, 0, 1'b1);
        add_req(OP_WRITE, 0, 0, 1'b1);
        add_req(OP_WRITE, 15, 15, 1'b1);
        add_req(OP_WRITE, 1, 2, 1'b1);
        add_req(OP_WRITE, 0, 1, 1'b1);
        add_req(OP_RUN, 0, 0, 1'b0);
        wait_idle();
        cfg_write(CFG_TRAVERSAL_MODE, CFG_DATA_W'(MODE_DFS));
        @(negedge i_clk);
        add_req(OP_RUN, 15, 15, 1'b1);
        add_req(OP_WRITE, 0, 1, 1'b0);
        add_req(OP_RUN, 0, 0, 1'b0);
        wait_idle();
        cfg_write(CFG_ACTIVE_NODES, 5'd0);
        @(negedge i_clk);
        add_req(OP_RUN, 0, 0, 1'b0);
        wait_idle();
        cfg_write(CFG_ACTIVE_NODES, 5'd31);
        @(negedge i_clk);
        add_req(OP_WRITE, 15, 1, 1'b1);
        add_req(OP_RUN, 0, 0, 1'b0);
        wait_idle();
        cfg_write(CFG_ACTIVE_NODES, 5'd1);
        cfg_write(CFG_TRAVERSAL_MODE, CFG_DATA_W'(MODE_BFS));
        @(negedge i_clk);
        add_req(OP_RUN, 0, 0, 1'b0);
        wait_idle();
        cfg_write(CFG_ACTIVE_NODES, 5'd2);
        @(negedge i_clk);
        add_req(OP_WRITE, 1, 15, 1'b1);
        add_req(OP_RUN, 0, 0, 1'b0);
        wait_idle();

        // random: graph building bursts, each closed by a run
        rand_items = 0;
        phase      = 0;
        while (rand_items < 110) begin
            case ($urandom_range(0, 9))
                0: act = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(17, 31);
                1: act = 16;
                default: act = $urandom_range(1, 16);
            endcase
            cfg_write(CFG_ACTIVE_NODES, CFG_DATA_W'(act));
            cfg_write(CFG_TRAVERSAL_MODE, CFG_DATA_W'($urandom_range(0, 1)));
            lim = (act == 0) ? 0 : (act > NODES) ? NODES - 1 : act - 1;
            @(negedge i_clk);
            calm  = (phase == 2 || phase == 3);
            nruns = $urandom_range(1, 3);
            if (phase == 0) begin
                hold_req = 1'b1;
                nruns    = 3;
            end
            repeat (nruns) begin
                nw = $urandom_range(0, 10);
                repeat (nw) begin
                    if ($urandom_range(0, 99) < 85)
                        add_req(OP_WRITE, $urandom_range(0, lim), $urandom_range(0, lim),
                                $urandom_range(0, 99) < 75);
                    else
                        add_req(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                                $urandom_range(0, 1) != 0);
                end
                add_req(OP_RUN, $urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(0, 1) != 0);
                rand_items += nw + 1;
            end
            wait_idle();
            phase++;
        end
        calm = 1'b0;

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && visits_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
